@@ hw/rtl/bsrd_pkg.sv @@
// Shared types, constants and helpers for the scan report deduplicator.
// Used by the table search, the structure walker, the top level and the checker.
`timescale 1ns / 1ps
package bsrd_pkg;

  // Default number of address table entries
  localparam int DEFAULT_TABLE_DEPTH = 128;

  // Advertising data geometry
  localparam int ADV_BYTES   = 32;
  localparam int ADV_DATA_W  = ADV_BYTES * 8;
  localparam int ADDR_W      = 48;
  localparam int ADV_LEN_W   = 5;

  // Advertising structure types that carry a local name
  localparam logic [7:0] AD_NAME_SHORT    = 8'h08;
  localparam logic [7:0] AD_NAME_COMPLETE = 8'h09;

  // Input tdata layout
  localparam int IN_TDATA_W   = 312;
  localparam int IN_ADDR_LSB  = 0;
  localparam int IN_LEN_LSB   = 48;
  localparam int IN_BYTES_LSB = 53;

  // Output tdata layout
  localparam int OUT_TDATA_W       = 48;
  localparam int OUT_IS_NEW_BIT    = 0;
  localparam int OUT_STORED_BIT    = 1;
  localparam int OUT_NAME_BIT      = 2;
  localparam int OUT_NEW_TOT_LSB   = 3;
  localparam int OUT_NAMED_TOT_LSB = 19;
  localparam int OUT_USED_LSB      = 35;
  localparam int OUT_USED_MSB      = 42;

  // Top level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } ctrl_state_t;

  // Table search status
  typedef struct packed {
    logic done;
    logic found;
  } srch_res_t;

  // Table write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] data;
  } tbl_wr_t;

  // Structure walk status
  typedef struct packed {
    logic done;
    logic named;
  } walk_res_t;

  // Pick one advertising byte by index
  function automatic logic [7:0] adv_byte(input logic [ADV_DATA_W-1:0] data,
                                          input logic [4:0] idx);
    return data[{3'b000, idx} * 8 +: 8];
  endfunction

endpackage

@@ hw/rtl/ble_scan_report_dedup.sv @@
// Scan report deduplicator top level: sequencer, counters and output register.
// Depends on bsrd_pkg, bsrd_addr_table and bsrd_ad_walker.
//
// Usage:
//   in_* channel carries one scan report per request: advertiser address,
//   advertising length and 32 advertising bytes. out_* channel returns one
//   result per request: new/stored/named flags, the new and named running
//   totals (16 bits, wrapping) and the number of table entries in use.
//   The block holds one request at a time; in_tready is low from acceptance
//   until the result has been taken.
//   The result is ready once both the table search and the structure walk are
//   done: the table search reads one stored address per cycle from a single
//   memory port while the walker checks one advertising structure per cycle.
//   in_tready returns in the cycle after the result is taken.
//   While out_tready is low the result holds in the output register and no
//   new request is taken.
//   Reset empties the table (entry count to zero) and clears both totals; the
//   table memory itself is not swept.
`timescale 1ns / 1ps
module ble_scan_report_dedup
  import bsrd_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // address[47:0], adv_length[52:48], adv_bytes_0[116:53], adv_bytes_1[180:117],
  // adv_bytes_2[244:181], adv_bytes_3[308:245], zero fill [311:309]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // is_new[0], was_stored[1], has_name[2], new_total[18:3], named_total[34:19],
  // entries_used[42:35], zero fill [47:43]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  ctrl_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]     addr_r;
  logic [ADV_LEN_W-1:0]  len_r;
  logic [ADV_DATA_W-1:0] data_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [15:0]           new_tot_r, new_tot_nxt;
  logic [15:0]           named_tot_r, named_tot_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                  accept;
  logic                  commit;
  logic                  is_new;
  logic                  stored;
  logic                  named;
  logic [CNT_W+7:0]      cnt_ext;
  srch_res_t             srch;
  walk_res_t             walk;
  tbl_wr_t               tbl_wr;

  assign accept = in_tvalid && in_tready;
  assign commit = (state_r == ST_RUN) && srch.done && walk.done;
  assign is_new = !srch.found;
  assign stored = is_new && (cnt_r < DEPTH_CNT);
  assign named  = is_new && walk.named;

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_tdata[IN_ADDR_LSB +: ADDR_W];
      len_r  <= in_tdata[IN_LEN_LSB +: ADV_LEN_W];
      data_r <= in_tdata[IN_BYTES_LSB +: ADV_DATA_W];
    end
  end

  bsrd_addr_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .key    (addr_r),
    .count  (cnt_r),
    .wr     (tbl_wr),
    .wr_idx (cnt_r[IDX_W-1:0]),
    .res    (srch)
  );

  bsrd_ad_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .adv_len  (len_r),
    .ad_bytes (data_r),
    .res      (walk)
  );

  // Sequence the request and build the result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    new_tot_nxt   = new_tot_r;
    named_tot_nxt = named_tot_r;
    out_data_nxt  = out_data_r;
    tbl_wr.en     = 1'b0;
    tbl_wr.data   = addr_r;
    cnt_ext       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (commit) begin
          tbl_wr.en = stored;
          if (stored) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (is_new) begin
            new_tot_nxt = new_tot_r + 16'd1;
          end
          if (named) begin
            named_tot_nxt = named_tot_r + 16'd1;
          end
          cnt_ext = {8'h00, cnt_nxt};
          out_data_nxt = '0;
          out_data_nxt[OUT_IS_NEW_BIT] = is_new;
          out_data_nxt[OUT_STORED_BIT] = stored;
          out_data_nxt[OUT_NAME_BIT]   = named;
          out_data_nxt[OUT_NEW_TOT_LSB +: 16]   = new_tot_nxt;
          out_data_nxt[OUT_NAMED_TOT_LSB +: 16] = named_tot_nxt;
          out_data_nxt[OUT_USED_MSB:OUT_USED_LSB] = cnt_ext[7:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      new_tot_r   <= '0;
      named_tot_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      new_tot_r   <= new_tot_nxt;
      named_tot_r <= named_tot_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = out_data_r;

endmodule

@@ hw/rtl/bsrd_addr_table.sv @@
// Address table memory with a one-entry-per-cycle sequential search.
// Depends on bsrd_pkg for types and widths.
`timescale 1ns / 1ps
module bsrd_addr_table
  import bsrd_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  parameter int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] key,
  input  logic [CNT_W-1:0]  count,
  input  tbl_wr_t           wr,
  input  logic [IDX_W-1:0]  wr_idx,
  output srch_res_t         res
);

  logic [ADDR_W-1:0] mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] rd_data_r;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              found_r, found_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              hit;
  logic              finish;
  logic              rd_en;

  // Compare the entry read in the previous cycle
  assign hit    = pend_r && (rd_data_r == key);
  assign finish = busy_r && (hit || (idx_r >= count && !pend_r) ||
                             (idx_r >= count && pend_r && !hit));
  assign rd_en  = busy_r && !finish && (idx_r < count);

  // Advance the search pointer
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    found_nxt = found_r;
    pend_nxt  = 1'b0;
    idx_nxt   = idx_r;
    if (start) begin
      busy_nxt  = 1'b1;
      done_nxt  = 1'b0;
      found_nxt = 1'b0;
      idx_nxt   = '0;
    end else if (finish) begin
      busy_nxt  = 1'b0;
      done_nxt  = 1'b1;
      found_nxt = hit;
    end else if (rd_en) begin
      pend_nxt = 1'b1;
      idx_nxt  = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
      pend_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
      pend_r  <= pend_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Store one address; read one entry per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_idx] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  assign res.done  = done_r;
  assign res.found = found_r;

endmodule

@@ hw/rtl/bsrd_ad_walker.sv @@
// Walks the length-type advertising structures one structure per cycle.
// Depends on bsrd_pkg for the byte picker and name type codes.
`timescale 1ns / 1ps
module bsrd_ad_walker
  import bsrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ADV_LEN_W-1:0]  adv_len,
  input  logic [ADV_DATA_W-1:0] ad_bytes,
  output walk_res_t             res
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 named_r, named_nxt;
  logic [ADV_LEN_W-1:0] pos_r, pos_nxt;
  logic [7:0]           len_byte;
  logic [7:0]           type_byte;
  logic [8:0]           end_pos;

  assign len_byte  = adv_byte(ad_bytes, pos_r);
  assign type_byte = adv_byte(ad_bytes, pos_r + 5'd1);
  assign end_pos   = {4'b0000, pos_r} + {1'b0, len_byte} + 9'd1;

  // Check one structure and step past it
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    named_nxt = named_r;
    pos_nxt   = pos_r;
    if (start) begin
      busy_nxt  = 1'b1;
      done_nxt  = 1'b0;
      named_nxt = 1'b0;
      pos_nxt   = '0;
    end else if (busy_r) begin
      if (pos_r >= adv_len || len_byte == 8'd0 || end_pos > {4'b0000, adv_len}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (type_byte == AD_NAME_COMPLETE || type_byte == AD_NAME_SHORT) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        named_nxt = (len_byte > 8'd1);
      end else begin
        pos_nxt = end_pos[ADV_LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      named_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      named_r <= named_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign res.done  = done_r;
  assign res.named = named_r;

endmodule

@@ hw/rtl/bsrd_checker.sv @@
// Port-level checker for the scan report deduplicator, bound to the top level.
// Depends on bsrd_pkg for the output field layout.
`timescale 1ns / 1ps
module bsrd_checker
  import bsrd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Drop ready once a request is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // Never offer a result and take a request together
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while result pending");

  // A known address is neither stored nor named
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OUT_IS_NEW_BIT] |->
      !out_tdata[OUT_STORED_BIT] && !out_tdata[OUT_NAME_BIT])
    else $error("known address flagged stored or named");

  // Come out of reset with no result
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ble_scan_report_dedup bsrd_checker u_bsrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ dv/ble_scan_report_dedup_test.sv @@
// Self-checking testbench for the scan report deduplicator: directed reports first,
// then random ones, each result checked against its fixed answer or an in-bench address filter model.
// Depends on bsrd_pkg and ble_scan_report_dedup.
`timescale 1ns / 1ps
module ble_scan_report_dedup_test;
  import bsrd_pkg::*;

  localparam int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH;
  localparam int RANDOM_ITEMS = 1480;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 200;
  localparam int N_DIRECTED   = 18;

  // One result as it leaves the block
  typedef struct packed {
    logic        is_new;
    logic        was_stored;
    logic        has_name;
    logic [15:0] new_total;
    logic [15:0] named_total;
    logic [7:0]  entries_used;
  } report_result_t;

  // One directed request, with an optional fixed answer
  typedef struct packed {
    logic [ADDR_W-1:0]     addr;
    logic [ADV_LEN_W-1:0]  len;
    logic [ADV_DATA_W-1:0] data;
    logic                  fixed;
    report_result_t        want;
  } report_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Address filter model state
  logic [ADDR_W-1:0] seen_addrs [TABLE_DEPTH];
  int                seen_count;
  logic [15:0]       new_tally;
  logic [15:0]       named_tally;

  report_result_t    pending_results[$];
  logic [ADDR_W-1:0] sent_addrs[$];
  int                error_count;
  bit                send_steady;
  bit                take_steady;
  bit                sink_hold;
  int                hold_count;

  report_row_t directed_rows [N_DIRECTED];

  ble_scan_report_dedup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  // Walk the length-type structures; the first name structure decides
  function automatic bit carries_local_name(logic [ADV_DATA_W-1:0] d, int n);
    int         pos;
    int         l;
    logic [7:0] kind;
    pos = 0;
    while (pos < n) begin
      l = d[pos*8 +: 8];
      if (l == 0) return 0;
      if (pos + l + 1 > n) return 0;
      kind = d[((pos + 1) % ADV_BYTES)*8 +: 8];
      if (kind == AD_NAME_COMPLETE || kind == AD_NAME_SHORT) return l > 1;
      pos += l + 1;
    end
    return 0;
  endfunction

  // Look up the address, store it if new and room is left, update the totals
  function automatic report_result_t dedup_report(logic [ADDR_W-1:0] a,
                                                  logic [ADV_LEN_W-1:0] n,
                                                  logic [ADV_DATA_W-1:0] d);
    report_result_t r;
    bit             hit;
    r   = '0;
    hit = 0;
    for (int i = 0; i < seen_count; i++)
      if (seen_addrs[i] == a) hit = 1;
    if (!hit) begin
      r.is_new = 1'b1;
      if (seen_count < TABLE_DEPTH) begin
        seen_addrs[seen_count] = a;
        seen_count++;
        r.was_stored = 1'b1;
      end
      new_tally++;
      if (carries_local_name(d, int'(n))) begin
        r.has_name = 1'b1;
        named_tally++;
      end
    end
    r.new_total    = new_tally;
    r.named_total  = named_tally;
    r.entries_used = seen_count[7:0];
    return r;
  endfunction

  // Print one line per mismatch and count it
  task automatic flag_error(string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Random advertising data: mostly well-formed structures, some noise and cut-offs
  task automatic build_adv_data(output logic [ADV_DATA_W-1:0] d,
                                output logic [ADV_LEN_W-1:0] n);
    int pos;
    int l;
    int pick;
    for (int w = 0; w < ADV_DATA_W / 32; w++) d[w*32 +: 32] = $urandom();
    if ($urandom_range(99) < 15) begin
      n = 5'($urandom_range(0, 31));
      return;
    end
    pos = 0;
    while (ADV_BYTES - 1 - pos >= 2) begin
      pick = $urandom_range(99);
      if (pick < 4) l = 0;
      else if (pick < 9) l = $urandom_range(1, 31);
      else l = $urandom_range(1, (ADV_BYTES - 2 - pos) < 12 ? (ADV_BYTES - 2 - pos) : 12);
      d[pos*8 +: 8] = l[7:0];
      case ($urandom_range(0, 5))
        0: d[(pos+1)*8 +: 8] = 8'h01;
        1: d[(pos+1)*8 +: 8] = AD_NAME_SHORT;
        2: d[(pos+1)*8 +: 8] = AD_NAME_COMPLETE;
        3: d[(pos+1)*8 +: 8] = 8'hFF;
        4: d[(pos+1)*8 +: 8] = 8'h0A;
        default: ;
      endcase
      pos += l + 1;
      if (l == 0 || $urandom_range(0, 5) == 0) break;
    end
    n = (pos > 31) ? 5'd31 : pos[4:0];
    if ($urandom_range(99) < 10) n = 5'($urandom_range(0, 31));
  endtask

  // Offer one request, hold it until taken, then record the expected result
  task automatic offer_report(logic [ADDR_W-1:0] a, logic [ADV_LEN_W-1:0] n,
                              logic [ADV_DATA_W-1:0] d, logic fixed,
                              report_result_t want);
    report_result_t got;
    while (!send_steady && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, d, n, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = dedup_report(a, n, d);
    pending_results.push_back(fixed ? want : got);
    sent_addrs.push_back(a);
    @(negedge clk);
  endtask

  // Wait with the input idle until every expected result has arrived
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Result side: random stalls, a steady stretch and one long hold-off
  initial begin
    out_tready = 1'b0;
    hold_count = 0;
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        out_tready <= 1'b0;
        hold_count++;
        if (hold_count == HOLD_CYCLES) begin
          sink_hold  = 0;
          hold_count = 0;
        end
      end else begin
        out_tready <= take_steady || ($urandom_range(99) >= 26);
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    report_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result %h", out_tdata));
      end else begin
        want = pending_results.pop_front();
        check_field("is_new", 16'(out_tdata[OUT_IS_NEW_BIT]), 16'(want.is_new));
        check_field("was_stored", 16'(out_tdata[OUT_STORED_BIT]), 16'(want.was_stored));
        check_field("has_name", 16'(out_tdata[OUT_NAME_BIT]), 16'(want.has_name));
        check_field("new_total", out_tdata[OUT_NEW_TOT_LSB +: 16], want.new_total);
        check_field("named_total", out_tdata[OUT_NAMED_TOT_LSB +: 16], want.named_total);
        check_field("entries_used", 16'(out_tdata[OUT_USED_LSB +: 8]),
                    16'(want.entries_used));
      end
    end
  end

  // Give up if the run hangs
  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Main sequence
  initial begin
    logic [ADDR_W-1:0]     a;
    logic [ADV_DATA_W-1:0] d;
    logic [ADV_LEN_W-1:0]  n;
    int                    pick;

    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    seen_count  = 0;
    new_tally   = '0;
    named_tally = '0;
    error_count = 0;
    send_steady = 0;
    take_steady = 0;
    sink_hold   = 0;

    // Directed reports; bytes read right to left, byte 0 lowest
    directed_rows = '{
      // empty table, empty data
      '{48'h0, 5'd0, 256'h0, 1'b1, '{1'b1, 1'b1, 1'b0, 16'd1, 16'd0, 8'd1}},
      // all-ones address, complete name with one byte, trailing 0xFF bytes
      '{48'hFFFF_FFFF_FFFF, 5'd31, {{29{8'hFF}}, 24'h41_09_02}, 1'b1,
        '{1'b1, 1'b1, 1'b1, 16'd2, 16'd1, 8'd2}},
      // both known again: no change
      '{48'h0, 5'd31, {32{8'hFF}}, 1'b1, '{1'b0, 1'b0, 1'b0, 16'd2, 16'd1, 8'd2}},
      '{48'hFFFF_FFFF_FFFF, 5'd0, 256'h0, 1'b1, '{1'b0, 1'b0, 1'b0, 16'd2, 16'd1, 8'd2}},
      // short name with type byte only
      '{48'h0000_0000_0001, 5'd2, 256'h08_01, 1'b0, '0},
      // zero length byte ends the walk
      '{48'h8000_0000_0000, 5'd3, 256'h41_09_00, 1'b0, '0},
      // structure reaches past the data
      '{48'h0123_4567_89AB, 5'd4, 256'h42_41_09_05, 1'b0, '0},
      // structure ends exactly at the data end
      '{48'h0123_4567_89AA, 5'd6, 256'h44_43_42_41_09_05, 1'b0, '0},
      // flags structure, then a short name
      '{48'h0000_0000_0010, 5'd7, 256'h42_41_08_03_06_01_02, 1'b0, '0},
      // first name structure is empty, a later one is not
      '{48'h0000_0000_0020, 5'd6, 256'h42_41_09_03_09_01, 1'b0, '0},
      // one structure fills all 31 bytes
      '{48'h0000_0000_0040, 5'd31, {8'h00, {29{8'h41}}, 8'h09, 8'h1E}, 1'b0, '0},
      // name bytes lie beyond the length
      '{48'h0000_0000_0080, 5'd0, 256'h41_09_02, 1'b0, '0},
      // other structure type
      '{48'h0000_0000_0100, 5'd3, 256'h41_0A_02, 1'b0, '0},
      // single length byte with no room
      '{48'h0000_0000_0200, 5'd1, 256'h01, 1'b0, '0},
      // one byte too long
      '{48'h0000_0000_0400, 5'd31, {{30{8'h55}}, 8'h09, 8'h1F}, 1'b0, '0},
      // shortened name fitting a length of 30
      '{48'h0000_0000_0800, 5'd30, {{30{8'h41}}, 8'h08, 8'h1D}, 1'b0, '0},
      // known address with a name
      '{48'h0123_4567_89AA, 5'd6, 256'h44_43_42_41_09_05, 1'b0, '0},
      // all-zero data
      '{48'hA5A5_5A5A_C3C3, 5'd31, 256'h0, 1'b0, '0}
    };

    // Hold reset, then release it at a falling clock edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      offer_report(directed_rows[i].addr, directed_rows[i].len, directed_rows[i].data,
                   directed_rows[i].fixed, directed_rows[i].want);
    drain_results();

    // Random reports: fresh, known, unstored and near-miss addresses
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 200) sink_hold = 1;
      if (k == 300) begin
        send_steady = 1;
        take_steady = 1;
      end
      if (k == 500) begin
        send_steady = 0;
        take_steady = 0;
      end
      if (k == 700) drain_results();

      pick = $urandom_range(99);
      if (pick < 40 || seen_count == 0) begin
        a = {16'($urandom()), 32'($urandom())};
      end else if (pick < 70) begin
        a = seen_addrs[$urandom_range(0, seen_count - 1)];
      end else if (pick < 88) begin
        a = sent_addrs[$urandom_range(0, sent_addrs.size() - 1)];
      end else begin
        a = seen_addrs[$urandom_range(0, seen_count - 1)];
        a[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
      end
      build_adv_data(d, n);
      offer_report(a, n, d, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    // Drain, then allow stray results to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
